@@ hw/rtl/wsdb_pkg.sv @@
// shared codes for the work-stealing deque bank
package wsdb_pkg;

  typedef enum logic [2:0] {
    MODE_PUSH_RIGHT = 3'd0,
    MODE_PUSH_LEFT  = 3'd1,
    MODE_POP_RIGHT  = 3'd2,
    MODE_POP_LEFT   = 3'd3,
    MODE_FIND_WORK  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  localparam int unsigned WORKER_W = 4;
  localparam int unsigned SOURCE_W = 4;
  localparam int unsigned ACTIVE_W = 5;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

endpackage

@@ hw/rtl/wsdb_ram.sv @@
// generic single-write, single-read ram with registered read data
module wsdb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/work_stealing_deque_bank_top.sv @@
// Work-stealing deque bank: NUM_DEQUES rings of DEQUE_DEPTH jobs, one per worker. Every
// request gives one result. A push, or any request that fails (full, empty, bad worker,
// unknown mode, no work found), runs as follows: the deque's left index and count are read
// from the counter ram, then updated and the job written. A pop that succeeds adds a
// registered read of the job ram after the counter update. One request is in flight at a
// time; a finished result waits in the output register without blocking the next request.
// Find work picks the lowest non-empty deque below active_workers from a per-deque
// non-empty flag. Counter entries never written read as zero through per-deque valid flags,
// so there is no clearing pass after reset.
module work_stealing_deque_bank_top #(
  parameter int unsigned NUM_DEQUES  = 16,
  parameter int unsigned DEQUE_DEPTH = 64,
  parameter int unsigned INDEX_BITS  = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [wsdb_pkg::ACTIVE_W-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          mode,
  input  logic [wsdb_pkg::WORKER_W-1:0]       worker,
  input  logic [INDEX_BITS-1:0]               job_low,
  input  logic signed [INDEX_BITS:0]          job_high,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          status,
  output logic [INDEX_BITS-1:0]               out_low,
  output logic signed [INDEX_BITS:0]          out_high,
  output logic [wsdb_pkg::SOURCE_W-1:0]       source_deque
);

  localparam int unsigned DW     = $clog2(NUM_DEQUES);
  localparam int unsigned SLOT_W = $clog2(DEQUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEQUE_DEPTH + 1);
  localparam int unsigned CTR_W  = SLOT_W + CNT_W;
  localparam int unsigned JOB_W  = 2 * INDEX_BITS + 1;
  localparam int unsigned JDEPTH = NUM_DEQUES * DEQUE_DEPTH;
  localparam int unsigned JAW    = $clog2(JDEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CTR,
    S_JOB,
    S_WAIT
  } state_t;

  state_t state;

  logic [wsdb_pkg::ACTIVE_W-1:0] active_workers;
  logic [NUM_DEQUES-1:0]         nonempty;
  logic [NUM_DEQUES-1:0]         ctr_valid;

  // request registers
  logic                    op_go;
  logic                    op_push;
  logic                    op_right;
  logic [DW-1:0]           op_d;
  logic [INDEX_BITS-1:0]   op_low;
  logic [INDEX_BITS:0]     op_high;
  logic                    rd_valid;

  // result waiting for the output register
  logic [1:0]                    hold_status;
  logic [INDEX_BITS-1:0]         hold_low;
  logic [INDEX_BITS:0]           hold_high;
  logic [wsdb_pkg::SOURCE_W-1:0] hold_src;

  // ram ports
  logic             ctr_we;
  logic [CTR_W-1:0] ctr_wdata;
  logic [CTR_W-1:0] ctr_rdata;
  logic             job_we;
  logic [JAW-1:0]   job_addr;
  logic [JOB_W-1:0] job_rdata;

  function automatic logic [SLOT_W-1:0] ring_add(input logic [SLOT_W-1:0] a,
                                                 input logic [SLOT_W-1:0] b);
    logic [SLOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (SLOT_W+1)'(DEQUE_DEPTH)) begin
      s = s - (SLOT_W+1)'(DEQUE_DEPTH);
    end
    return s[SLOT_W-1:0];
  endfunction

  // request decode at the input transfer
  logic          acc;
  logic          found_any;
  logic [DW-1:0] found_d;
  logic          worker_ok;
  logic          acc_go;
  logic          acc_push;
  logic          acc_right;
  logic [DW-1:0] acc_d;

  assign in_stall = (state != S_IDLE);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    found_any = 1'b0;
    found_d   = '0;
    for (int i = NUM_DEQUES - 1; i >= 0; i--) begin
      if (nonempty[i] && (32'(i) < 32'(active_workers))) begin
        found_any = 1'b1;
        found_d   = DW'(i);
      end
    end
    worker_ok = 32'(worker) < NUM_DEQUES;
    acc_go    = 1'b0;
    acc_push  = 1'b0;
    acc_right = 1'b0;
    acc_d     = DW'(worker);
    case (mode)
      wsdb_pkg::MODE_PUSH_RIGHT: begin
        acc_go    = worker_ok;
        acc_push  = 1'b1;
        acc_right = 1'b1;
      end
      wsdb_pkg::MODE_PUSH_LEFT: begin
        acc_go   = worker_ok;
        acc_push = 1'b1;
      end
      wsdb_pkg::MODE_POP_RIGHT: begin
        acc_go    = worker_ok;
        acc_right = 1'b1;
      end
      wsdb_pkg::MODE_POP_LEFT: begin
        acc_go = worker_ok;
      end
      wsdb_pkg::MODE_FIND_WORK: begin
        acc_go    = found_any;
        acc_d     = found_d;
        // own deque pops right, any other deque is stolen from the left
        acc_right = (32'(found_d) == 32'(worker));
      end
      default: begin
        acc_go = 1'b0;
      end
    endcase
  end

  // counter update
  logic [CNT_W-1:0]  cnt;
  logic [SLOT_W-1:0] left;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  new_cnt;
  logic [SLOT_W-1:0] new_left;
  logic [SLOT_W-1:0] slot;
  logic              ok;

  always_comb begin
    cnt    = rd_valid ? ctr_rdata[CNT_W-1:0] : '0;
    left   = rd_valid ? ctr_rdata[CTR_W-1:CNT_W] : '0;
    cnt_m1 = cnt - CNT_W'(1);
    if (op_push) begin
      ok       = op_go && (cnt != CNT_W'(DEQUE_DEPTH));
      slot     = op_right ? ring_add(left, cnt[SLOT_W-1:0])
                          : ring_add(left, SLOT_W'(DEQUE_DEPTH - 1));
      new_left = op_right ? left : slot;
      new_cnt  = cnt + CNT_W'(1);
    end else begin
      ok       = op_go && (cnt != '0);
      slot     = op_right ? ring_add(left, cnt_m1[SLOT_W-1:0]) : left;
      new_left = op_right ? left : ring_add(left, SLOT_W'(1));
      new_cnt  = cnt_m1;
    end
    ctr_we    = (state == S_CTR) && ok;
    ctr_wdata = {new_left, new_cnt};
    job_we    = (state == S_CTR) && ok && op_push;
    job_addr  = JAW'(op_d) * JAW'(DEQUE_DEPTH) + JAW'(slot);
  end

  // result of the finishing step
  logic                          out_free;
  logic                          out_load;
  logic                          fin;
  logic [1:0]                    fin_status;
  logic [INDEX_BITS-1:0]         fin_low;
  logic [INDEX_BITS:0]           fin_high;
  logic [wsdb_pkg::SOURCE_W-1:0] fin_src;

  assign out_free = !out_valid || !out_stall;
  assign out_load = (((state == S_CTR) || (state == S_JOB)) && fin && out_free)
                    || ((state == S_WAIT) && out_free);

  always_comb begin
    fin        = 1'b0;
    fin_status = wsdb_pkg::STATUS_EMPTY;
    fin_low    = '0;
    fin_high   = '0;
    fin_src    = '0;
    case (state)
      S_CTR: begin
        fin = !(ok && !op_push);
        if (ok) begin
          fin_status = wsdb_pkg::STATUS_DONE;
        end else if (op_push) begin
          fin_status = wsdb_pkg::STATUS_FULL;
        end else begin
          fin_status = wsdb_pkg::STATUS_EMPTY;
        end
      end
      S_JOB: begin
        fin        = 1'b1;
        fin_status = wsdb_pkg::STATUS_DONE;
        fin_low    = job_rdata[INDEX_BITS-1:0];
        fin_high   = job_rdata[JOB_W-1:INDEX_BITS];
        fin_src    = wsdb_pkg::SOURCE_W'(op_d);
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      nonempty       <= '0;
      ctr_valid      <= '0;
      active_workers <= wsdb_pkg::ACTIVE_RESET;
    end else begin
      if (cfg_write) begin
        active_workers <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (ctr_we) begin
        ctr_valid[op_d] <= 1'b1;
        nonempty[op_d]  <= op_push ? 1'b1 : (new_cnt != '0);
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            op_go    <= acc_go;
            op_push  <= acc_push;
            op_right <= acc_right;
            op_d     <= acc_d;
            op_low   <= job_low;
            op_high  <= job_high;
            rd_valid <= ctr_valid[acc_d];
            state    <= S_CTR;
          end
        end
        S_CTR, S_JOB: begin
          if (!fin) begin
            state <= S_JOB;
          end else if (out_free) begin
            status       <= fin_status;
            out_low      <= fin_low;
            out_high     <= signed'(fin_high);
            source_deque <= fin_src;
            state        <= S_IDLE;
          end else begin
            hold_status <= fin_status;
            hold_low    <= fin_low;
            hold_high   <= fin_high;
            hold_src    <= fin_src;
            state       <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (out_free) begin
            status       <= hold_status;
            out_low      <= hold_low;
            out_high     <= signed'(hold_high);
            source_deque <= hold_src;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  wsdb_ram #(
    .WIDTH (CTR_W),
    .DEPTH (NUM_DEQUES)
  ) u_ctr_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (op_d),
    .wdata (ctr_wdata),
    .raddr (acc_d),
    .rdata (ctr_rdata)
  );

  wsdb_ram #(
    .WIDTH (JOB_W),
    .DEPTH (JDEPTH)
  ) u_job_ram (
    .clk   (clk),
    .we    (job_we),
    .waddr (job_addr),
    .wdata ({op_high, op_low}),
    .raddr (job_addr),
    .rdata (job_rdata)
  );

endmodule
